[hdl/sedm_pkg.sv]
// ----------------------------------------------------------------------------
// sedm_pkg
// Shared types and constants for the stereo echo delay mixer.
// ----------------------------------------------------------------------------
package sedm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAMES_W   = 14;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int CFG_IDX_W  = 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic        [FRAMES_W-1:0] frames_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_GAIN    = 1'd1;

    localparam frames_t DELAY_FRAMES_RST = '0;
    localparam gain_t   ECHO_GAIN_RST    = 16'sd8192;

    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // How the delayed term of an item is formed
    typedef struct packed {
        logic zero_delay;  // delayed term is the item itself
        logic tap_ok;      // enough history: use the delay-line read
    } tap_ctrl_t;

endpackage

[hdl/stereo_echo_delay_mixer.sv]
// ----------------------------------------------------------------------------
// stereo_echo_delay_mixer
// Feedforward comb echo on interleaved stereo: y = x + sat(trunc(g * x[n-D])).
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one signed 16-bit interleaved sample (left, right, ...);
//   s_tuser[0] marks the first sample of a new stream, which clears history.
//   m_tdata returns one wrapped 16-bit result per accepted item, in order.
//   D = 2 * delay_frames, capped at MAX_DELAY_SAMPLES; the delayed term is
//   zero until D samples of the current stream have gone in. Feed D zero
//   samples to flush the echo tail.
// Timing:
//   One item per cycle sustained while m_tready stays high. The delay-line
//   read and write share the accept cycle on one memory; results are
//   registered through the memory read, the product and the output register.
// Reset:
//   delay_frames = 0, echo_gain = 0.5 (Q2.14), pointer and history cleared.
//   Delay-line contents are not cleared; the history gate keeps stale slots
//   from being used. Write configuration only while the block is idle.
// Stall:
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module stereo_echo_delay_mixer #(
    parameter int MAX_DELAY_SAMPLES = 32768
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sedm_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample_in
    input  logic [0:0]                         s_tuser,   // [0] stream_start
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sedm_pkg::SAMPLE_W-1:0]      m_tdata,   // [15:0] sample_out
    // Configuration
    input  logic                               cfg_we,
    input  logic [sedm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sedm_pkg::GAIN_W-1:0]        cfg_wdata
);

    sedm_pkg::frames_t   delay_frames_reg;
    sedm_pkg::gain_t     echo_gain_reg;
    logic                advance, accept;
    logic                tap_valid;
    sedm_pkg::sample_t   tap_x, tap_data, out_sample;
    sedm_pkg::tap_ctrl_t tap_ctrl;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_frames_reg <= sedm_pkg::DELAY_FRAMES_RST;
            echo_gain_reg    <= sedm_pkg::ECHO_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sedm_pkg::CFG_DELAY_FRAMES: begin
                    delay_frames_reg <= cfg_wdata[sedm_pkg::FRAMES_W-1:0];
                end
                sedm_pkg::CFG_ECHO_GAIN: begin
                    echo_gain_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    sedm_line #(
        .MAX_DELAY_SAMPLES (MAX_DELAY_SAMPLES)
    ) u_line (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .advance      (advance),
        .sample_in    (s_tdata),
        .stream_start (s_tuser[0]),
        .delay_frames (delay_frames_reg),
        .tap_valid    (tap_valid),
        .tap_x        (tap_x),
        .tap_data     (tap_data),
        .tap_ctrl     (tap_ctrl)
    );

    sedm_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .tap_valid  (tap_valid),
        .tap_x      (tap_x),
        .tap_data   (tap_data),
        .tap_ctrl   (tap_ctrl),
        .echo_gain  (echo_gain_reg),
        .out_valid  (m_tvalid),
        .out_sample (out_sample)
    );

    assign m_tdata = out_sample;

endmodule

[hdl/sedm_line.sv]
// ----------------------------------------------------------------------------
// sedm_line
// Delay-line memory with write pointer and history gate. Writes the
// accepted sample and reads the tap in the same cycle (read-first).
// ----------------------------------------------------------------------------
module sedm_line #(
    parameter int MAX_DELAY_SAMPLES = 32768
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                advance,
    input  sedm_pkg::sample_t   sample_in,
    input  logic                stream_start,
    input  sedm_pkg::frames_t   delay_frames,
    output logic                tap_valid,
    output sedm_pkg::sample_t   tap_x,
    output sedm_pkg::sample_t   tap_data,
    output sedm_pkg::tap_ctrl_t tap_ctrl
);

    localparam int PTR_W  = $clog2(MAX_DELAY_SAMPLES);
    localparam int HIST_W = $clog2(MAX_DELAY_SAMPLES + 1);
    localparam int DW     = (HIST_W > sedm_pkg::FRAMES_W + 1) ? HIST_W
                                                              : sedm_pkg::FRAMES_W + 1;
    localparam logic [DW:0]       MAX_D    = (DW + 1)'(MAX_DELAY_SAMPLES);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_DELAY_SAMPLES - 1);
    localparam logic [HIST_W-1:0] HIST_MAX = HIST_W'(MAX_DELAY_SAMPLES);

    sedm_pkg::sample_t mem [MAX_DELAY_SAMPLES];

    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [HIST_W-1:0] hist_reg, hist_next, hist_eff;
    logic [DW:0]       d_full, d_sat, wptr_ext, rptr_ext;
    logic [PTR_W-1:0]  rptr;
    logic              valid_reg;
    sedm_pkg::sample_t x_reg, rd_reg;
    sedm_pkg::tap_ctrl_t ctrl_reg, ctrl_next;

    always_comb begin
        d_full   = (DW + 1)'({delay_frames, 1'b0});
        d_sat    = (d_full > MAX_D) ? MAX_D : d_full;
        hist_eff = stream_start ? '0 : hist_reg;
        wptr_ext = (DW + 1)'(wptr_reg);
        rptr_ext = (wptr_ext >= d_sat) ? (wptr_ext - d_sat) : (wptr_ext + MAX_D - d_sat);
        rptr     = rptr_ext[PTR_W-1:0];

        ctrl_next.zero_delay = (d_sat == '0);
        ctrl_next.tap_ok     = ((DW + 1)'(hist_eff) >= d_sat);

        wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        hist_next = (hist_eff < HIST_MAX) ? hist_eff + 1'b1 : hist_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            hist_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                wptr_reg <= wptr_next;
                hist_reg <= hist_next;
            end
            if (advance) begin
                valid_reg <= accept;
            end
        end
    end

    // Read-first: a tap at the slot being overwritten sees the old sample
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[wptr_reg] <= sample_in;
            rd_reg        <= mem[rptr];
            x_reg         <= sample_in;
            ctrl_reg      <= ctrl_next;
        end
    end

    assign tap_valid = valid_reg;
    assign tap_x     = x_reg;
    assign tap_data  = rd_reg;
    assign tap_ctrl  = ctrl_reg;

endmodule

[hdl/sedm_mix.sv]
// ----------------------------------------------------------------------------
// sedm_mix
// Gain multiply, truncation toward zero, saturation and the wrapping add.
// Two register stages: product, then the output item.
// ----------------------------------------------------------------------------
module sedm_mix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                tap_valid,
    input  sedm_pkg::sample_t   tap_x,
    input  sedm_pkg::sample_t   tap_data,
    input  sedm_pkg::tap_ctrl_t tap_ctrl,
    input  sedm_pkg::gain_t     echo_gain,
    output logic                out_valid,
    output sedm_pkg::sample_t   out_sample
);

    localparam int SH_W = sedm_pkg::PROD_W - sedm_pkg::GAIN_FRAC;

    sedm_pkg::sample_t delayed;
    sedm_pkg::prod_t   prod_reg, prod_adj;
    sedm_pkg::sample_t px_reg, scaled, sum;
    logic              pvalid_reg, ovalid_reg;
    logic signed [SH_W-1:0] shifted;
    sedm_pkg::sample_t out_reg;

    always_comb begin
        if (tap_ctrl.zero_delay) begin
            delayed = tap_x;
        end else if (tap_ctrl.tap_ok) begin
            delayed = tap_data;
        end else begin
            delayed = '0;
        end
    end

    // Bias negative products so the arithmetic shift truncates toward zero
    always_comb begin
        prod_adj = prod_reg + (prod_reg[sedm_pkg::PROD_W-1]
                   ? sedm_pkg::PROD_W'((1 << sedm_pkg::GAIN_FRAC) - 1) : '0);
        shifted  = prod_adj[sedm_pkg::PROD_W-1:sedm_pkg::GAIN_FRAC];
        if (shifted > SH_W'(sedm_pkg::SAMPLE_MAX)) begin
            scaled = sedm_pkg::SAMPLE_MAX;
        end else if (shifted < SH_W'(sedm_pkg::SAMPLE_MIN)) begin
            scaled = sedm_pkg::SAMPLE_MIN;
        end else begin
            scaled = shifted[sedm_pkg::SAMPLE_W-1:0];
        end
        sum = px_reg + scaled;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else if (advance) begin
            pvalid_reg <= tap_valid;
            ovalid_reg <= pvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= echo_gain * delayed;
            px_reg   <= tap_x;
            out_reg  <= sum;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_sample = out_reg;

endmodule

[bench/stereo_echo_delay_mixer_tb.sv]
// ----------------------------------------------------------------------------
// stereo_echo_delay_mixer_tb
// Self-checking bench for the stereo echo delay mixer. A directed opening
// covers the reset settings, zero delay, gain and sample extremes,
// truncation toward zero, saturation, wrapping sums and short history.
// Random streams follow under changing settings and random source and sink
// stalls. A final stream at the largest delay checks that the history gate
// keeps the echo off. Every result is compared in order against a predicted
// echo output.
// ----------------------------------------------------------------------------
module stereo_echo_delay_mixer_tb;

    localparam int DEPTH       = 32768;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    // ------------------------------------------------------------------------
    // Echo predictor and store of expected output samples
    // ------------------------------------------------------------------------
    class echo_scoreboard;
        sedm_pkg::sample_t past_in [DEPTH];
        int                wr_pos;
        int                seen;
        sedm_pkg::frames_t delay_frames;
        sedm_pkg::gain_t   echo_gain;
        sedm_pkg::sample_t expected_out[$];
        int                errors;

        function new();
            wr_pos       = 0;
            seen         = 0;
            delay_frames = sedm_pkg::DELAY_FRAMES_RST;
            echo_gain    = sedm_pkg::ECHO_GAIN_RST;
            errors       = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void set_reg(input logic [sedm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [sedm_pkg::GAIN_W-1:0] val);
            if (idx == sedm_pkg::CFG_DELAY_FRAMES) begin
                delay_frames = val[sedm_pkg::FRAMES_W-1:0];
            end else if (idx == sedm_pkg::CFG_ECHO_GAIN) begin
                echo_gain = sedm_pkg::gain_t'(val);
            end
        endfunction

        // gain * x / 2^14, truncated toward zero, clamped to 16 bits
        function sedm_pkg::sample_t echo_term(input sedm_pkg::gain_t g,
                                              input sedm_pkg::sample_t x);
            int prod;
            int mag;
            prod = int'(g) * int'(x);
            mag  = (prod < 0 ? -prod : prod) >> sedm_pkg::GAIN_FRAC;
            if (prod < 0) begin
                mag = -mag;
            end
            if (mag > 32767) begin
                mag = 32767;
            end else if (mag < -32768) begin
                mag = -32768;
            end
            return sedm_pkg::sample_t'(mag);
        endfunction

        function void note_input(input sedm_pkg::sample_t x, input logic first);
            int                span;
            sedm_pkg::sample_t tap;
            sedm_pkg::sample_t term;
            if (first) begin
                seen = 0;
            end
            span = 2 * int'(delay_frames);
            if (span > DEPTH) begin
                span = DEPTH;
            end
            if (span == 0) begin
                tap = x;
            end else if (seen >= span) begin
                tap = past_in[(wr_pos - span + DEPTH) % DEPTH];
            end else begin
                tap = '0;
            end
            term = echo_term(echo_gain, tap);
            expected_out.push_back(sedm_pkg::sample_t'(x + term));
            past_in[wr_pos] = x;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (seen < DEPTH) begin
                seen++;
            end
        endfunction

        task check_result(input sedm_pkg::sample_t got);
            sedm_pkg::sample_t want;
            if (expected_out.size() == 0) begin
                report($sformatf("sample_out %0d with nothing expected", got));
            end else begin
                want = expected_out.pop_front();
                if (got !== want) begin
                    report($sformatf("sample_out got %0d expected %0d", got, want));
                end
            end
        endtask

        function int pending();
            return expected_out.size();
        endfunction

        task close();
            if (expected_out.size() != 0) begin
                report($sformatf("%0d results never came", expected_out.size()));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, ports
    // ------------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [sedm_pkg::SAMPLE_W-1:0]  s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [sedm_pkg::SAMPLE_W-1:0]  m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [sedm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sedm_pkg::GAIN_W-1:0]    cfg_wdata = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles      = 0;

    echo_scoreboard sb;

    always #6 aclk = ~aclk;

    stereo_echo_delay_mixer #(
        .MAX_DELAY_SAMPLES(DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // sink stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(sedm_pkg::sample_t'(s_tdata), s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(sedm_pkg::sample_t'(m_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input sedm_pkg::sample_t x, input logic first);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid and hold until every expected sample is back; waiting on a
    // clock edge first lets the last accepted item reach the scoreboard
    task automatic wait_drained(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sedm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sedm_pkg::GAIN_W-1:0] val);
        wait_drained(SETTLE);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_index <= 1'($urandom);
        cfg_wdata <= 16'($urandom);
        sb.set_reg(idx, val);
    endtask

    function automatic sedm_pkg::sample_t pick_sample();
        case ($urandom_range(9))
            0:       return sedm_pkg::SAMPLE_MAX;
            1:       return sedm_pkg::SAMPLE_MIN;
            2, 3:    return sedm_pkg::sample_t'(int'($urandom_range(64)) - 32);
            default: return sedm_pkg::sample_t'($urandom);
        endcase
    endfunction

    function automatic sedm_pkg::gain_t pick_gain();
        case ($urandom_range(7))
            0:       return sedm_pkg::gain_t'(16'sh8000);
            1:       return sedm_pkg::gain_t'(16'sh7fff);
            2:       return sedm_pkg::gain_t'(16'sd16384);
            3:       return sedm_pkg::gain_t'(-16'sd16384);
            default: return sedm_pkg::gain_t'($urandom);
        endcase
    endfunction

    function automatic sedm_pkg::frames_t pick_delay();
        case ($urandom_range(7))
            0:       return '0;
            1:       return sedm_pkg::frames_t'($urandom);
            2, 3:    return sedm_pkg::frames_t'($urandom_range(1, 8));
            default: return sedm_pkg::frames_t'($urandom_range(9, 40));
        endcase
    endfunction

    // one run of items; new streams start now and then
    task automatic run_items(input int count, input logic fresh);
        int pause_at;
        pause_at = ($urandom_range(2) == 0) ? int'($urandom_range(count - 1)) : -1;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                wait_drained(0);
            end
            send_item(pick_sample(),
                      (i == 0) ? fresh : logic'($urandom_range(199) == 0));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic send_list(input sedm_pkg::sample_t xs[$], input logic fresh);
        for (int i = 0; i < xs.size(); i++) begin
            send_item(xs[i], (i == 0) ? fresh : 1'b0);
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 27;
        rx_idle_pct = 59;

        // reset settings: zero delay, half gain
        send_list('{sedm_pkg::SAMPLE_MAX, sedm_pkg::SAMPLE_MIN, 16'sd0, 16'sd1,
                    -16'sd1, 16'sd16384, -16'sd16383}, 1'b1);

        // most negative gain: product clamps high
        write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'h8000);
        send_list('{sedm_pkg::SAMPLE_MIN, sedm_pkg::SAMPLE_MAX, -16'sd1, 16'sd1},
                  1'b0);

        // largest gain: clamped product, wrapping sum
        write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'h7fff);
        send_list('{sedm_pkg::SAMPLE_MAX, sedm_pkg::SAMPLE_MIN, 16'sd2}, 1'b0);

        // tiny gain: truncation toward zero
        write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'h0001);
        send_list('{-16'sd1, 16'sd1, -16'sd16385, 16'sd16383}, 1'b1);

        // two frames of delay; upper data bits must be dropped
        write_reg(sedm_pkg::CFG_DELAY_FRAMES, 16'hc002);
        write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'h4000);
        send_list('{16'sd100, 16'sd200, -16'sd300, 16'sd400, 16'sd500,
                    -16'sd600, sedm_pkg::SAMPLE_MAX}, 1'b1);

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 59;
                rx_idle_pct = 27;
            end else if (ph == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(2))
                0: write_reg(sedm_pkg::CFG_DELAY_FRAMES,
                             {2'($urandom), 14'(pick_delay())});
                1: write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'(pick_gain()));
                default: begin
                    write_reg(sedm_pkg::CFG_DELAY_FRAMES,
                              {2'($urandom), 14'(pick_delay())});
                    write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'(pick_gain()));
                end
            endcase
            // sometimes keep the stream going across the change
            run_items(int'($urandom_range(90, 120)), logic'($urandom_range(3) != 0));
        end

        // longest delay; history stays short, so no echo is added
        write_reg(sedm_pkg::CFG_DELAY_FRAMES, 16'h3fff);
        write_reg(sedm_pkg::CFG_ECHO_GAIN, 16'(pick_gain()));
        for (int i = 0; i < 64; i++) begin
            send_item(pick_sample(), logic'(i == 0));
        end
        s_tvalid <= 1'b0;

        wait_drained(SETTLE);
        sb.close();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
